/* design/o1bcpt_pkg.sv */
`timescale 1ns / 1ps

package o1bcpt_pkg;

  localparam int unsigned IDX_W  = 16;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CFG_W  = 32;

  localparam logic [CFG_W-1:0] MIN_TOTAL_RESET = 32'd2;
  localparam logic [BYTE_W-1:0] CTX_START      = 8'd1;
  localparam logic [3:0]        ACC_STEPS      = 4'd8;

  typedef enum logic [1:0] {
    OP_ACCUM = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_CLR,
    ST_RD_ISSUE,
    ST_RD_SUM,
    ST_RD_START,
    ST_RD_WAIT
  } state_e;

endpackage

/* design/o1bcpt_div.sv */
`timescale 1ns / 1ps

module o1bcpt_div #(
  parameter int unsigned COUNT_BITS = 32,
  parameter int unsigned PROB_BITS  = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [COUNT_BITS:0]   dividend_i,
  input  logic [COUNT_BITS+1:0] divisor_i,
  output logic                  done_o,
  output logic [PROB_BITS-1:0]  quot_o
);

  localparam int unsigned CW    = COUNT_BITS;
  localparam int unsigned CNT_W = $clog2(PROB_BITS + 1);

  logic [CW+1:0]      rem_q, rem_d;
  logic [CW+1:0]      den_q;
  logic [PROB_BITS-1:0] quot_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               run_q;
  logic               done_q;

  logic [CW+2:0] shifted;
  logic [CW+2:0] diff;
  logic          ge;

  always_comb begin
    shifted = {rem_q, 1'b0};
    ge      = shifted >= {1'b0, den_q};
    diff    = shifted - {1'b0, den_q};
    rem_d   = ge ? diff[CW+1:0] : shifted[CW+1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CNT_W'(PROB_BITS);
      end else if (run_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {1'b0, dividend_i};
      den_q  <= divisor_i;
      quot_q <= '0;
    end else if (run_q) begin
      rem_q  <= rem_d;
      quot_q <= {quot_q[PROB_BITS-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

/* design/order1_bit_context_prior_trainer.sv */
`timescale 1ns / 1ps

// Channel   Direction  Ports                                        Handshake
// command   in         op_i, data_byte_i, entry_index_i             start & !busy
// result    out        read_index_o, meets_threshold_o,             strobe_o, one cycle
//                      probability_o, packed_entry_o
// config    in         cfg_wdata_i                                  cfg_we_i
//
// Accumulate: eight counter reads on the read port overlapped with write-backs on the
//   write port, then the last write-back, during which the next command can be accepted.
// Read: counter read, sum and compare, then the bit-serial divider and the strobe.
// Clear and reset: a pass that zeroes every entry of the counter memory, busy held high.
// Results cannot be stalled; each strobe lasts one cycle.

module order1_bit_context_prior_trainer #(
  parameter int unsigned COUNT_BITS = 32,
  parameter int unsigned PROB_BITS  = 12
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [1:0]                            op_i,
  input  logic [o1bcpt_pkg::BYTE_W-1:0]         data_byte_i,
  input  logic [o1bcpt_pkg::IDX_W-1:0]          entry_index_i,
  input  logic                                  cfg_we_i,
  input  logic [o1bcpt_pkg::CFG_W-1:0]          cfg_wdata_i,
  output logic                                  strobe_o,
  output logic [o1bcpt_pkg::IDX_W-1:0]          read_index_o,
  output logic                                  meets_threshold_o,
  output logic [PROB_BITS-1:0]                  probability_o,
  output logic [o1bcpt_pkg::IDX_W+PROB_BITS-1:0] packed_entry_o
);

  localparam int unsigned CW    = COUNT_BITS;
  localparam int unsigned EW    = 2 * COUNT_BITS;
  localparam int unsigned IW    = o1bcpt_pkg::IDX_W;
  localparam int unsigned BW    = o1bcpt_pkg::BYTE_W;
  localparam int unsigned DEPTH = 1 << o1bcpt_pkg::IDX_W;
  localparam int unsigned CMP_W = (COUNT_BITS + 1 > o1bcpt_pkg::CFG_W) ?
                                  COUNT_BITS + 1 : o1bcpt_pkg::CFG_W;

  o1bcpt_pkg::state_e state_q, state_d;

  logic [3:0]     acc_k_q, acc_k_d;
  logic [BW-1:0]  ctx_q, ctx_d;
  logic [IW-1:0]  clr_cnt_q, clr_cnt_d;
  logic [BW-1:0]  prev_q;
  logic [BW-1:0]  byte_q;
  logic [IW-1:0]  idx_q;
  logic [IW-1:0]  wr_addr_q;
  logic           wr_bit_q;
  logic [o1bcpt_pkg::CFG_W-1:0] min_q;

  logic [EW-1:0]  mem_q [DEPTH];
  logic [EW-1:0]  rdata_q;
  logic           mem_re, mem_we;
  logic [IW-1:0]  mem_raddr, mem_waddr;
  logic [EW-1:0]  mem_wdata;

  logic [CW-1:0]  ones_q;
  logic [CW:0]    total_q;
  logic           meets_q;

  logic           strobe_q;
  logic [IW-1:0]  out_idx_q;
  logic           out_meets_q;
  logic [PROB_BITS-1:0] out_prob_q;

  logic           ready;
  logic           accept;
  logic           acc_bit;
  logic [CW-1:0]  cnt_zero, cnt_one, zero_inc, one_inc;
  logic [EW-1:0]  acc_wdata;

  logic           div_start;
  logic           div_done;
  logic [PROB_BITS-1:0] div_quot;

  assign ready  = (state_q == o1bcpt_pkg::ST_IDLE) ||
                  ((state_q == o1bcpt_pkg::ST_ACC) && (acc_k_q == o1bcpt_pkg::ACC_STEPS));
  assign accept = start && ready;
  assign busy   = !ready;

  assign acc_bit  = byte_q[3'd7 - acc_k_q[2:0]];
  assign cnt_zero = rdata_q[CW-1:0];
  assign cnt_one  = rdata_q[EW-1:CW];
  assign zero_inc = (&cnt_zero) ? cnt_zero : cnt_zero + CW'(1);
  assign one_inc  = (&cnt_one) ? cnt_one : cnt_one + CW'(1);
  assign acc_wdata = wr_bit_q ? {one_inc, cnt_zero} : {cnt_one, zero_inc};

  always_comb begin
    state_d   = state_q;
    acc_k_d   = acc_k_q;
    ctx_d     = ctx_q;
    clr_cnt_d = clr_cnt_q;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_raddr = {prev_q, ctx_q};
    mem_waddr = wr_addr_q;
    mem_wdata = acc_wdata;
    div_start = 1'b0;
    unique case (state_q)
      o1bcpt_pkg::ST_IDLE: begin
      end
      o1bcpt_pkg::ST_ACC: begin
        if (acc_k_q != o1bcpt_pkg::ACC_STEPS) begin
          mem_re  = 1'b1;
          ctx_d   = {ctx_q[BW-2:0], acc_bit};
          acc_k_d = acc_k_q + 4'd1;
        end else begin
          state_d = o1bcpt_pkg::ST_IDLE;
        end
        if (acc_k_q != 4'd0) begin
          mem_we = 1'b1;
        end
      end
      o1bcpt_pkg::ST_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = '0;
        clr_cnt_d = clr_cnt_q + IW'(1);
        if (&clr_cnt_q) begin
          state_d = o1bcpt_pkg::ST_IDLE;
        end
      end
      o1bcpt_pkg::ST_RD_ISSUE: begin
        mem_re    = 1'b1;
        mem_raddr = idx_q;
        state_d   = o1bcpt_pkg::ST_RD_SUM;
      end
      o1bcpt_pkg::ST_RD_SUM: begin
        state_d = o1bcpt_pkg::ST_RD_START;
      end
      o1bcpt_pkg::ST_RD_START: begin
        div_start = 1'b1;
        state_d   = o1bcpt_pkg::ST_RD_WAIT;
      end
      o1bcpt_pkg::ST_RD_WAIT: begin
        if (div_done) begin
          state_d = o1bcpt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = o1bcpt_pkg::ST_IDLE;
      end
    endcase
    if (accept) begin
      unique case (op_i)
        o1bcpt_pkg::OP_ACCUM: begin
          state_d = o1bcpt_pkg::ST_ACC;
          acc_k_d = 4'd0;
          ctx_d   = o1bcpt_pkg::CTX_START;
        end
        o1bcpt_pkg::OP_READ: begin
          state_d = o1bcpt_pkg::ST_RD_ISSUE;
        end
        o1bcpt_pkg::OP_CLEAR: begin
          state_d   = o1bcpt_pkg::ST_CLR;
          clr_cnt_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= o1bcpt_pkg::ST_CLR;
      acc_k_q   <= '0;
      ctx_q     <= o1bcpt_pkg::CTX_START;
      clr_cnt_q <= '0;
      prev_q    <= '0;
      min_q     <= o1bcpt_pkg::MIN_TOTAL_RESET;
      strobe_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      acc_k_q   <= acc_k_d;
      ctx_q     <= ctx_d;
      clr_cnt_q <= clr_cnt_d;
      if (cfg_we_i) begin
        min_q <= cfg_wdata_i;
      end
      if (accept && (op_i == o1bcpt_pkg::OP_CLEAR)) begin
        prev_q <= '0;
      end else if ((state_q == o1bcpt_pkg::ST_ACC) && (acc_k_q == o1bcpt_pkg::ACC_STEPS)) begin
        prev_q <= byte_q;
      end
      strobe_q <= (state_q == o1bcpt_pkg::ST_RD_WAIT) && div_done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= data_byte_i;
      idx_q  <= entry_index_i;
    end
    if (state_q == o1bcpt_pkg::ST_ACC) begin
      wr_addr_q <= mem_raddr;
      wr_bit_q  <= acc_bit;
    end
    if (state_q == o1bcpt_pkg::ST_RD_SUM) begin
      ones_q  <= cnt_one;
      total_q <= {1'b0, cnt_zero} + {1'b0, cnt_one};
    end
    if (state_q == o1bcpt_pkg::ST_RD_START) begin
      meets_q <= CMP_W'(total_q) >= CMP_W'(min_q);
    end
    if ((state_q == o1bcpt_pkg::ST_RD_WAIT) && div_done) begin
      out_idx_q   <= idx_q;
      out_meets_q <= meets_q;
      out_prob_q  <= (div_quot == '0) ? PROB_BITS'(1) : div_quot;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  o1bcpt_div #(
    .COUNT_BITS (COUNT_BITS),
    .PROB_BITS  (PROB_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({1'b0, ones_q} + (CW+1)'(1)),
    .divisor_i  ({1'b0, total_q} + (CW+2)'(2)),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign strobe_o          = strobe_q;
  assign read_index_o      = out_idx_q;
  assign meets_threshold_o = out_meets_q;
  assign probability_o     = out_prob_q;
  assign packed_entry_o    = {out_idx_q, out_prob_q};

endmodule

/* design/o1bcpt_checker.sv */
`timescale 1ns / 1ps

module o1bcpt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic [1:0] op_i,
  input logic       strobe_o
);

  logic accept;
  logic valid_op;

  assign accept   = start && !busy;
  assign valid_op = (op_i == o1bcpt_pkg::OP_ACCUM) || (op_i == o1bcpt_pkg::OP_READ) ||
                    (op_i == o1bcpt_pkg::OP_CLEAR);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |=> !strobe_o)
    else $error("result strobe held for two cycles");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(busy))
    else $error("result without a preceding busy cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && valid_op) |=> busy)
    else $error("accepted transaction did not raise busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !strobe_o)
    else $error("result strobe right after an accepted transaction");

endmodule

bind order1_bit_context_prior_trainer o1bcpt_checker u_o1bcpt_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .op_i     (op_i),
  .strobe_o (strobe_o)
);
